// File: rtl/core/hotp_pkg.sv
// Shared constants and helpers for the HOTP code generator.
`default_nettype none
package hotp_pkg;
  localparam int MAX_KEY_BYTES_DEF = 20;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 64;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KEY_0_7   = 3'd0,
    REG_KEY_8_15  = 3'd1,
    REG_KEY_16_19 = 3'd2,
    REG_KEY_LEN   = 3'd3,
    REG_DIGITS    = 3'd4,
    REG_HEX       = 3'd5
  } cfg_reg_t;

  localparam logic [159:0] SHA1_IV =
    160'h67452301_EFCDAB89_98BADCFE_10325476_C3D2E1F0;
  localparam logic [7:0] IPAD = 8'h36;
  localparam logic [7:0] OPAD = 8'h5C;
  localparam logic [31:0] PAD_WORD = 32'h8000_0000;
  localparam logic [31:0] INNER_BITS = 32'd576;  // 72-byte message
  localparam logic [31:0] OUTER_BITS = 32'd672;  // 84-byte message

  // Power of ten for 1..9 digits.
  function automatic logic [29:0] dec_pow(input logic [3:0] nd);
    logic [29:0] p;
    p = 30'd1;
    case (nd)
      4'd1: p = 30'd10;
      4'd2: p = 30'd100;
      4'd3: p = 30'd1000;
      4'd4: p = 30'd10000;
      4'd5: p = 30'd100000;
      4'd6: p = 30'd1000000;
      4'd7: p = 30'd10000000;
      4'd8: p = 30'd100000000;
      4'd9: p = 30'd1000000000;
      default: p = 30'd1;
    endcase
    return p;
  endfunction
endpackage
`default_nettype wire

// File: rtl/core/hotp_sha1_core.sv
// SHA-1 compression unit: one round per cycle over a 16-word schedule window.
`default_nettype none
module hotp_sha1_core (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         start,
  input  wire logic         load_iv,
  input  wire logic [511:0] blk,
  output logic              done,
  output logic [159:0]      h_out
);
  logic [31:0]  win_r [16];
  logic [31:0]  a_r, b_r, c_r, d_r, e_r;
  logic [159:0] h_r;
  logic [6:0]   round_r;
  logic         busy_r, done_r;
  logic [159:0] h_base;
  logic [31:0]  f, k, t, w_new, sx;

  assign h_base = load_iv ? hotp_pkg::SHA1_IV : h_r;
  assign sx = win_r[13] ^ win_r[8] ^ win_r[2] ^ win_r[0];
  assign w_new = {sx[30:0], sx[31]};

  always_comb begin
    if (round_r < 7'd20) begin
      f = (b_r & c_r) | (~b_r & d_r); k = 32'h5A827999;
    end else if (round_r < 7'd40) begin
      f = b_r ^ c_r ^ d_r; k = 32'h6ED9EBA1;
    end else if (round_r < 7'd60) begin
      f = (b_r & c_r) | (b_r & d_r) | (c_r & d_r); k = 32'h8F1BBCDC;
    end else begin
      f = b_r ^ c_r ^ d_r; k = 32'hCA62C1D6;
    end
    t = {a_r[26:0], a_r[31:27]} + f + e_r + k + win_r[0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      round_r <= '0;
    end else begin
      done_r <= busy_r && !start && (round_r == 7'd79);
      if (start) begin
        busy_r <= 1'b1;
        round_r <= '0;
      end else if (busy_r) begin
        round_r <= round_r + 7'd1;
        if (round_r == 7'd79) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      for (int i = 0; i < 16; i++) win_r[i] <= blk[511-32*i -: 32];
      a_r <= h_base[159:128];
      b_r <= h_base[127:96];
      c_r <= h_base[95:64];
      d_r <= h_base[63:32];
      e_r <= h_base[31:0];
      h_r <= h_base;
    end else if (busy_r) begin
      for (int i = 0; i < 15; i++) win_r[i] <= win_r[i+1];
      win_r[15] <= w_new;
      a_r <= t;
      b_r <= a_r;
      c_r <= {b_r[1:0], b_r[31:2]};
      d_r <= c_r;
      e_r <= d_r;
      if (round_r == 7'd79) begin
        h_r <= {h_r[159:128] + t, h_r[127:96] + a_r,
                h_r[95:64] + {b_r[1:0], b_r[31:2]}, h_r[63:32] + c_r,
                h_r[31:0] + d_r};
      end
    end
  end

  assign done = done_r;
  assign h_out = h_r;
endmodule
`default_nettype wire

// File: rtl/core/hotp_mod_unit.sv
// Decimal remainder unit: strips digits above the kept count, one compare-subtract per cycle.
`default_nettype none
module hotp_mod_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [30:0] dividend,
  input  wire logic [3:0]  digits,
  output logic             done,
  output logic [30:0]      rem
);
  logic [30:0] rem_r;
  logic [3:0]  pos_r, last_r;
  logic [1:0]  step_r;
  logic        busy_r, done_r;
  logic        last_step;
  logic [29:0] pw;
  logic [32:0] part;
  logic [33:0] diff;

  // each decimal position is cleared by trying 8, 4, 2 and 1 times its power
  assign pw = hotp_pkg::dec_pow(pos_r);
  assign last_step = (step_r == 2'd3) && (pos_r == last_r);

  always_comb begin
    case (step_r)
      2'd0: part = {pw, 3'b000};
      2'd1: part = {1'b0, pw, 2'b00};
      2'd2: part = {2'b00, pw, 1'b0};
      default: part = {3'b000, pw};
    endcase
  end

  assign diff = {3'b000, rem_r} - {1'b0, part};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      pos_r <= '0;
      step_r <= '0;
    end else begin
      done_r <= busy_r && !start && last_step;
      if (start) begin
        busy_r <= 1'b1;
        pos_r <= 4'd9;
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + 2'd1;
        if (step_r == 2'd3) begin
          if (pos_r == last_r) busy_r <= 1'b0;
          else pos_r <= pos_r - 4'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= dividend;
      last_r <= digits;
    end else if (busy_r && !diff[33]) begin
      rem_r <= diff[30:0];
    end
  end

  assign done = done_r;
  assign rem = rem_r;
endmodule
`default_nettype wire

// File: rtl/core/hotp_code_generator.sv
// Top level of the HOTP code generator: config, sequencer, truncation.
`default_nettype none
// Each request carries a 64-bit moving counter and yields one code. The
// counter is authenticated with HMAC-SHA1 under the configured key, the
// RFC 4226 dynamic truncation picks a 31-bit value, and that value is cut
// to the clamped digit count (decimal remainder or hex mask). Four SHA-1
// compressions run on one shared round unit, each a load, 80 rounds and a
// handoff. Hex codes and ten-digit decimal codes skip the remainder unit.
// Decimal codes under ten digits go through it, and it clears each decimal
// position above the kept count in turn. A stalled output register delays
// the handoff of the code. in_stall stays high from acceptance until the
// code is handed to the output register.
// Configuration must be written while no request is in flight.
module hotp_code_generator #(
  parameter int MAX_KEY_BYTES = hotp_pkg::MAX_KEY_BYTES_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic [63:0]                     in_moving_count,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic [30:0]                          out_otp_value,
  output logic [3:0]                           out_digits_used,
  input  wire logic                            cfg_we,
  input  wire logic [hotp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [hotp_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_IN1   = 8'b0000_0010,
    S_IN2   = 8'b0000_0100,
    S_OUT1  = 8'b0000_1000,
    S_OUT2  = 8'b0001_0000,
    S_TRUNC = 8'b0010_0000,
    S_MOD   = 8'b0100_0000,
    S_FIN   = 8'b1000_0000
  } state_t;

  state_t state_r;
  logic [63:0]  key0_r, key1_r, ctr_r;
  logic [31:0]  key2_r;
  logic [4:0]   klen_r;
  logic [3:0]   ndig_r;
  logic         hex_r;
  logic [159:0] dig_r;
  logic [30:0]  val_r, otp_r;
  logic [3:0]   digits_r;
  logic         out_valid_r, start_r, mod_start_r;
  logic         fin_load;

  // key and configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key0_r <= '0;
      key1_r <= '0;
      key2_r <= '0;
      klen_r <= 5'd20;
      ndig_r <= 4'd6;
      hex_r  <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        hotp_pkg::REG_KEY_0_7:   key0_r <= cfg_wdata;
        hotp_pkg::REG_KEY_8_15:  key1_r <= cfg_wdata;
        hotp_pkg::REG_KEY_16_19: key2_r <= cfg_wdata[31:0];
        hotp_pkg::REG_KEY_LEN:   klen_r <= cfg_wdata[4:0];
        hotp_pkg::REG_DIGITS:    ndig_r <= cfg_wdata[3:0];
        hotp_pkg::REG_HEX:       hex_r  <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // masked key, padded with zero bytes past the effective length
  logic [4:0]   klen_eff;
  logic [159:0] key_all, key_msk;
  assign klen_eff = (klen_r > 5'(MAX_KEY_BYTES)) ? 5'(MAX_KEY_BYTES) : klen_r;
  assign key_all = {key0_r, key1_r, key2_r};
  always_comb begin
    for (int i = 0; i < 20; i++)
      key_msk[159-8*i -: 8] = (5'(i) < klen_eff) ? key_all[159-8*i -: 8] : 8'h00;
  end

  // block fed to the compression unit in each phase
  logic [511:0] blk;
  logic         load_iv;
  always_comb begin
    blk = '0;
    load_iv = 1'b0;
    unique case (state_r)
      S_IN1: begin
        blk = {key_msk ^ {20{hotp_pkg::IPAD}}, {44{hotp_pkg::IPAD}}};
        load_iv = 1'b1;
      end
      S_IN2:  blk = {ctr_r, hotp_pkg::PAD_WORD, 384'h0, hotp_pkg::INNER_BITS};
      S_OUT1: begin
        blk = {key_msk ^ {20{hotp_pkg::OPAD}}, {44{hotp_pkg::OPAD}}};
        load_iv = 1'b1;
      end
      S_OUT2: blk = {dig_r, hotp_pkg::PAD_WORD, 288'h0, hotp_pkg::OUTER_BITS};
      default: ;
    endcase
  end

  logic         sha_done;
  logic [159:0] sha_h;
  hotp_sha1_core u_sha (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start_r),
    .load_iv (load_iv),
    .blk     (blk),
    .done    (sha_done),
    .h_out   (sha_h)
  );

  // digit clamp
  logic [3:0] nd;
  always_comb begin
    if (ndig_r == 4'd0) nd = 4'd1;
    else if (hex_r && ndig_r > 4'd8) nd = 4'd8;
    else if (!hex_r && ndig_r > 4'd10) nd = 4'd10;
    else nd = ndig_r;
  end

  // dynamic truncation: offset from low nibble of the last byte,
  // top bit of the selected word dropped
  logic [3:0]  off;
  logic [7:0]  top_bit;
  logic [30:0] trunc, hex_mask;
  assign off = dig_r[3:0];
  assign top_bit = 8'd158 - {1'b0, off, 3'b000};
  assign trunc = dig_r[top_bit -: 31] ;
  assign hex_mask = ~(31'h7FFF_FFFF << {nd, 2'b00});

  logic        mod_done;
  logic [30:0] mod_rem;
  hotp_mod_unit u_mod (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (mod_start_r),
    .dividend (val_r),
    .digits   (nd),
    .done     (mod_done),
    .rem      (mod_rem)
  );

  // output register takes the code once it is empty or being drained
  assign fin_load = (state_r == S_FIN) && (!out_valid_r || !out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      start_r <= 1'b0;
      mod_start_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      start_r <= (state_r == S_IDLE && in_valid) ||
                 (sha_done && (state_r == S_IN1 || state_r == S_IN2 ||
                               state_r == S_OUT1));
      mod_start_r <= (state_r == S_TRUNC) && !hex_r && (nd != 4'd10);
      out_valid_r <= fin_load || (out_valid_r && out_stall);
      unique case (state_r)
        S_IDLE:  if (in_valid) state_r <= S_IN1;
        S_IN1:   if (sha_done) state_r <= S_IN2;
        S_IN2:   if (sha_done) state_r <= S_OUT1;
        S_OUT1:  if (sha_done) state_r <= S_OUT2;
        S_OUT2:  if (sha_done) state_r <= S_TRUNC;
        S_TRUNC: begin
          if (!hex_r && nd != 4'd10) state_r <= S_MOD;
          else state_r <= S_FIN;
        end
        S_MOD:   if (mod_done) state_r <= S_FIN;
        S_FIN:   if (fin_load) state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_valid) ctr_r <= in_moving_count;
    if (sha_done && (state_r == S_IN2 || state_r == S_OUT2)) dig_r <= sha_h;
    if (state_r == S_TRUNC) begin
      // hex keeps 4 bits per digit; 8 digits masks nothing
      val_r <= (hex_r && nd != 4'd8) ? (trunc & hex_mask) : trunc;
    end
    if (state_r == S_MOD && mod_done) val_r <= mod_rem;
    if (fin_load) begin
      otp_r <= val_r;
      digits_r <= nd;
    end
  end

  assign in_stall = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_otp_value = otp_r;
  assign out_digits_used = digits_r;
endmodule
`default_nettype wire
